>>> src/cbs_pkg.sv
// Package for the column bubble sort block: word types, controller states and
// the command and status bundles between controller and datapath. No dependencies.
package cbs_pkg;

  // Default number of kept elements per run
  localparam int DEPTH_DEF = 32;
  // Number of matrix columns; columns at or above this are never kept
  localparam int MAX_COLS  = 16;
  // Width used to compare a column index against MAX_COLS
  localparam int COL_CMP_W = 9;

  localparam int VAL_W = 32;
  localparam int COL_W = 4;

  // Input word: one matrix element
  typedef struct packed {
    logic signed [VAL_W-1:0] element_value;
    logic [COL_W-1:0]        element_column;
    logic                    matrix_end;
  } cbs_in_t;

  // Output word: one sorted value
  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic                    run_last;
    logic                    overflow_seen;
  } cbs_out_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_RD0,
    ST_RD1,
    ST_CMP,
    ST_WLAST,
    ST_ERD,
    ST_EWR
  } cbs_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_en;     // input word accepted
    logic init_sort;   // set pass limit to count - 1
    logic pass_start;  // read entry 0, restart position and swap flag
    logic take_carry;  // latch entry 0 as the bubble, read position
    logic compare;     // compare bubble with read entry, write back smaller
    logic write_last;  // write bubble at pass limit, shrink limit
    logic emit_rd;     // read entry at output index
    logic emit_wr;     // load output register
    logic run_clear;   // empty the store for the next run
  } cbs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic at_lim;
    logic swap;
    logic lim_one;
    logic emit_last;
    logic out_free;
  } cbs_sts_t;

endpackage

>>> src/column_bubble_sort.sv
// Column bubble sort: collects one column of a streamed matrix, sorts it
// ascending and sends it out. Depends on cbs_pkg, cbs_ctrl and cbs_datapath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i): one matrix element a
//   word. Words whose column equals the configured column are kept, up to
//   DEPTH of them; further ones are dropped and flagged. A word with
//   matrix_end set closes the load; the input stalls until the run is out.
//   Output channel (out_valid_o / out_stall_i / out_word_o): the kept values
//   in ascending order, run_last on the final word, overflow_seen on every
//   word of a run that dropped values. A run with nothing kept sends nothing.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): column select,
//   always ready; write it only while the block is idle.
// Sequence:
//   Loading takes one word a cycle. Sorting n values starts with the ST_START and
//   ST_RD0 states, then passes over the value store (one read, one write a cycle):
//   at most n - 1 passes, ending at the first pass with no swap. Output reads each
//   word from the store, then loads it into the output register, waiting while
//   the receiver stalls; the output register holds its word.
// Reset: clears the store count, drop flag, indices, column select and output valid, and sets the swap flag.
module column_bubble_sort
  import cbs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cbs_in_t          in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cbs_out_t         out_word_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [COL_W-1:0] cfg_data_i
);

  cbs_cmd_t cmd;
  cbs_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  cbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_word_i.matrix_end),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Store, compare and output
  cbs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

>>> src/cbs_ctrl.sv
// Controller state machine for the column bubble sort block: load, sort passes
// and output burst. Depends on cbs_pkg.
module cbs_ctrl
  import cbs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  input  cbs_sts_t sts_i,
  output cbs_cmd_t cmd_o,
  output logic     in_stall_o
);

  cbs_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_en = 1'b1;
          if (in_last_i) begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        if (sts_i.cnt_zero) begin
          cmd_o.run_clear = 1'b1;
          state_d         = ST_LOAD;
        end else if (sts_i.cnt_one) begin
          state_d = ST_ERD;
        end else begin
          cmd_o.init_sort = 1'b1;
          state_d         = ST_RD0;
        end
      end
      ST_RD0: begin
        cmd_o.pass_start = 1'b1;
        state_d          = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.take_carry = 1'b1;
        state_d          = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
        if (sts_i.at_lim) begin
          state_d = ST_WLAST;
        end
      end
      ST_WLAST: begin
        cmd_o.write_last = 1'b1;
        // Start the next pass at once, or stop when sorted
        if (sts_i.swap && !sts_i.lim_one) begin
          cmd_o.pass_start = 1'b1;
          state_d          = ST_RD1;
        end else begin
          state_d = ST_ERD;
        end
      end
      ST_ERD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_EWR;
      end
      ST_EWR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_wr = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.run_clear = 1'b1;
            state_d         = ST_LOAD;
          end else begin
            state_d = ST_ERD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

>>> src/cbs_datapath.sv
// Datapath for the column bubble sort block: value store, bubble register,
// pass counters, column register and output register. Depends on cbs_pkg.
module cbs_datapath
  import cbs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cbs_cmd_t         cmd_i,
  input  cbs_in_t          in_word_i,
  input  logic             cfg_valid_i,
  input  logic [COL_W-1:0] cfg_data_i,
  input  logic             out_stall_i,
  output cbs_sts_t         sts_o,
  output logic             out_valid_o,
  output cbs_out_t         out_word_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_q;
  logic signed [VAL_W-1:0] carry_q, carry_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    drop_q, drop_d;
  logic [AW-1:0]           pos_q, pos_d;
  logic [AW-1:0]           lim_q, lim_d;
  logic [AW-1:0]           idx_q, idx_d;
  logic                    swap_q, swap_d;
  logic [COL_W-1:0]        col_sel_q;
  logic                    out_valid_q, out_valid_d;
  cbs_out_t                out_word_q;

  logic                    we, re;
  logic [AW-1:0]           waddr, raddr;
  logic signed [VAL_W-1:0] wdata;
  logic                    sel, has_room, gt, at_lim, emit_last;

  assign sel = (in_word_i.element_column == col_sel_q) &&
               (COL_CMP_W'(in_word_i.element_column) < COL_CMP_W'(MAX_COLS));
  assign has_room  = cnt_q < CW'(DEPTH);
  assign gt        = carry_q > rd_q;
  assign at_lim    = pos_q == lim_q;
  assign emit_last = (CW'(idx_q) + CW'(1)) == cnt_q;

  // Memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = carry_q;
    re    = 1'b0;
    raddr = '0;
    if (cmd_i.load_en && sel && has_room) begin
      we    = 1'b1;
      waddr = cnt_q[AW-1:0];
      wdata = in_word_i.element_value;
    end
    if (cmd_i.compare) begin
      we    = 1'b1;
      waddr = pos_q - AW'(1);
      wdata = gt ? rd_q : carry_q;
      if (!at_lim) begin
        re    = 1'b1;
        raddr = pos_q + AW'(1);
      end
    end
    if (cmd_i.write_last) begin
      we    = 1'b1;
      waddr = lim_q;
      wdata = carry_q;
    end
    if (cmd_i.pass_start) begin
      re    = 1'b1;
      raddr = '0;
    end
    if (cmd_i.take_carry) begin
      re    = 1'b1;
      raddr = pos_q;
    end
    if (cmd_i.emit_rd) begin
      re    = 1'b1;
      raddr = idx_q;
    end
  end

  // Value store with registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // Next values of counters and flags
  always_comb begin
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    pos_d       = pos_q;
    lim_d       = lim_q;
    idx_d       = idx_q;
    swap_d      = swap_q;
    carry_d     = carry_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load_en && sel) begin
      if (has_room) begin
        cnt_d = cnt_q + CW'(1);
      end else begin
        drop_d = 1'b1;
      end
    end
    if (cmd_i.init_sort) begin
      lim_d = AW'(cnt_q - CW'(1));
    end
    if (cmd_i.pass_start) begin
      pos_d  = AW'(1);
      swap_d = 1'b0;
    end
    if (cmd_i.take_carry) begin
      carry_d = rd_q;
    end
    if (cmd_i.compare) begin
      if (gt) begin
        swap_d = 1'b1;
      end else begin
        carry_d = rd_q;
      end
      if (!at_lim) begin
        pos_d = pos_q + AW'(1);
      end
    end
    if (cmd_i.write_last) begin
      lim_d = lim_q - AW'(1);
    end
    if (cmd_i.emit_wr) begin
      idx_d       = idx_q + AW'(1);
      out_valid_d = 1'b1;
    end
    if (cmd_i.run_clear) begin
      cnt_d  = '0;
      drop_d = 1'b0;
      idx_d  = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      pos_q       <= '0;
      lim_q       <= '0;
      idx_q       <= '0;
      swap_q      <= 1'b1;
      col_sel_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      pos_q       <= pos_d;
      lim_q       <= lim_d;
      idx_q       <= idx_d;
      swap_q      <= swap_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        col_sel_q <= cfg_data_i;
      end
    end
  end

  // Bubble and output word registers
  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (cmd_i.emit_wr) begin
      out_word_q.sorted_value  <= rd_q;
      out_word_q.run_last      <= emit_last;
      out_word_q.overflow_seen <= drop_q;
    end
  end

  assign sts_o.cnt_zero  = cnt_q == '0;
  assign sts_o.cnt_one   = cnt_q == CW'(1);
  assign sts_o.at_lim    = at_lim;
  assign sts_o.swap      = swap_q;
  assign sts_o.lim_one   = lim_q == AW'(1);
  assign sts_o.emit_last = emit_last;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> src/cbs_checker.sv
// Port-level assertions for the column bubble sort block, bound to the top
// level. Depends on cbs_pkg and column_bubble_sort.
module cbs_checker
  import cbs_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input cbs_in_t  in_word_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input cbs_out_t out_word_o
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed or dropped");

  // Close the load on an accepted final element
  a_end_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.matrix_end |=> in_stall_o)
    else $error("input not stalled after matrix end");

  // Stall the input only after a final element
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && in_word_i.matrix_end))
    else $error("input stalled without matrix end");

  // Raise output valid only from the output phase, with the input closed
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word raised while input open");

endmodule

bind column_bubble_sort cbs_checker u_cbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
